FILE: rtl/mfd_pkg.sv
// Shared types, codes and constants of the message frame decoder.
package mfd_pkg;

   localparam int LENGTH_WIDTH_DEF = 32;
   localparam int HEADER_BYTES     = 8;
   localparam int CSR_INDEX_W      = 8;
   localparam int CSR_DATA_W       = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_VERSION_CODE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_BODY     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HELLO_CODE   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_CODE    = 8'd3;

   localparam logic [7:0]  VERSION_CODE_RST = 8'd1;
   localparam logic [31:0] MAX_BODY_RST     = 32'd65536;
   localparam logic [7:0]  HELLO_CODE_RST   = 8'd1;
   localparam logic [7:0]  DATA_CODE_RST    = 8'd2;

   typedef enum logic [1:0] {
      PH_LENGTH,
      PH_HEADER,
      PH_BODY
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ORIGIN,
      KIND_PAYLOAD,
      KIND_EMPTY,
      KIND_MALFORMED
   } kind_type;

   typedef struct packed {
      logic [7:0]  version_code;
      logic [31:0] max_body;
      logic [7:0]  hello_code;
      logic [7:0]  data_code;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value_byte;
      logic [7:0]  msg_type;
      logic [7:0]  hop_count;
      logic [31:0] sequence_res;
      logic [7:0]  origin_length;
      logic        frame_last;
   } result_type;

endpackage

FILE: rtl/mfd_if.sv
// Channel interfaces of the message frame decoder: byte requests, results, register writes.
interface mfd_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface mfd_result_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  value_byte;
   logic [7:0]  msg_type;
   logic [7:0]  hop_count;
   logic [31:0] sequence_res;
   logic [7:0]  origin_length;
   logic        frame_last;

   modport source (output valid, output kind, output value_byte, output msg_type,
                   output hop_count, output sequence_res, output origin_length,
                   output frame_last, input ready);
   modport sink (input valid, input kind, input value_byte, input msg_type,
                 input hop_count, input sequence_res, input origin_length,
                 input frame_last, output ready);
endinterface

interface mfd_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mfd_core.sv
// Frame parser: length, header checks, origin and payload tagging, one byte per request.
module mfd_core import mfd_pkg::*; #(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_fire,
   input  logic [7:0] in_byte,
   input  cfg_type    cfg,
   output logic       out_valid,
   output result_type out_result
);

   localparam int LEN_BYTES = LENGTH_WIDTH / 8;
   localparam int BW        = LEN_BYTES * 8;

   localparam logic [BW-1:0] LEN_LAST    = BW'(LEN_BYTES - 1);
   localparam logic [BW-1:0] HDR_LAST    = BW'(HEADER_BYTES - 1);
   localparam logic [BW-1:0] HDR_BYTES   = BW'(HEADER_BYTES);
   localparam logic [BW-1:0] IDX_VERSION = BW'(0);
   localparam logic [BW-1:0] IDX_TYPE    = BW'(1);
   localparam logic [BW-1:0] IDX_HOPS    = BW'(2);
   localparam logic [BW-1:0] IDX_ORIGIN  = BW'(3);

   phase_type     phase_ff, phase_in;
   logic [BW-1:0] idx_ff, idx_in;
   logic [BW-1:0] body_ff, body_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    hops_ff, hops_in;
   logic [7:0]    origin_ff, origin_in;
   logic [31:0]   seq_ff, seq_in;
   logic          error_ff, error_in;

   logic          emit;
   kind_type      emit_kind;
   logic [7:0]    emit_value;
   logic          emit_last;
   logic          fail;
   logic [BW-1:0] body_base;
   logic [BW-1:0] body_next;
   logic [BW-1:0] remaining;

   logic          res_valid_ff;
   result_type    res_ff;

   assign body_base = (idx_ff == '0) ? '0 : body_ff;
   assign body_next = {body_base[BW-9:0], in_byte};
   assign remaining = body_ff - HDR_BYTES;

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      body_in    = body_ff;
      type_in    = type_ff;
      hops_in    = hops_ff;
      origin_in  = origin_ff;
      seq_in     = seq_ff;
      error_in   = error_ff;
      emit       = 1'b0;
      emit_kind  = KIND_MALFORMED;
      emit_value = 8'd0;
      emit_last  = 1'b1;
      fail       = 1'b0;

      if (in_fire && !error_ff) begin
         case (phase_ff)
            PH_LENGTH: begin
               // Header fields of the previous frame are cleared on the first length byte.
               if (idx_ff == '0) begin
                  type_in   = 8'd0;
                  hops_in   = 8'd0;
                  origin_in = 8'd0;
                  seq_in    = 32'd0;
               end
               body_in = body_next;
               idx_in  = idx_ff + BW'(1);
               if (idx_ff == LEN_LAST) begin
                  idx_in = '0;
                  if ((33'(body_next) > 33'(cfg.max_body)) || (body_next < HDR_BYTES)) begin
                     fail = 1'b1;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end
            end
            PH_HEADER: begin
               idx_in = idx_ff + BW'(1);
               if (idx_ff == IDX_VERSION) begin
                  fail = (in_byte != cfg.version_code);
               end else if (idx_ff == IDX_TYPE) begin
                  type_in = in_byte;
                  fail    = (in_byte != cfg.hello_code) && (in_byte != cfg.data_code);
               end else if (idx_ff == IDX_HOPS) begin
                  hops_in = in_byte;
               end else if (idx_ff == IDX_ORIGIN) begin
                  origin_in = in_byte;
                  fail      = (HDR_BYTES + BW'(in_byte)) > body_ff;
               end else begin
                  seq_in = {seq_ff[23:0], in_byte};
               end
               if (!fail && idx_ff == HDR_LAST) begin
                  idx_in = '0;
                  if (body_ff == HDR_BYTES) begin
                     phase_in  = PH_LENGTH;
                     emit      = 1'b1;
                     emit_kind = KIND_EMPTY;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               emit       = 1'b1;
               emit_kind  = (idx_ff < BW'(origin_ff)) ? KIND_ORIGIN : KIND_PAYLOAD;
               emit_value = in_byte;
               emit_last  = (idx_ff + BW'(1)) >= remaining;
               if (emit_last) begin
                  phase_in = PH_LENGTH;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + BW'(1);
               end
            end
            default: begin
               phase_in = PH_LENGTH;
               idx_in   = '0;
            end
         endcase

         if (fail) begin
            error_in   = 1'b1;
            emit       = 1'b1;
            emit_kind  = KIND_MALFORMED;
            emit_value = 8'd0;
            emit_last  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LENGTH;
         idx_ff       <= '0;
         error_ff     <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         error_ff     <= error_in;
         res_valid_ff <= emit;
      end
   end

   // Header fields need no reset: the first length byte of each frame clears them.
   always_ff @(posedge clock) begin
      body_ff   <= body_in;
      type_ff   <= type_in;
      hops_ff   <= hops_in;
      origin_ff <= origin_in;
      seq_ff    <= seq_in;
      if (emit) begin
         res_ff.kind          <= emit_kind;
         res_ff.value_byte    <= emit_value;
         res_ff.msg_type      <= type_in;
         res_ff.hop_count     <= hops_in;
         res_ff.sequence_res  <= seq_in;
         res_ff.origin_length <= origin_in;
         res_ff.frame_last    <= emit_last;
      end
   end

   assign out_valid  = res_valid_ff;
   assign out_result = res_ff;

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff |=> error_ff)
      else $error("error latch cleared without reset");

   a_silent_after_error: assert property (@(posedge clock) disable iff (reset)
      $past(error_ff) |-> !res_valid_ff)
      else $error("result produced after a malformed frame");

   a_body_longer_than_header: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (body_ff > HDR_BYTES))
      else $error("body phase entered with no origin or payload bytes");

   a_header_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (idx_ff <= HDR_LAST))
      else $error("header byte index out of range");

   a_body_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (idx_ff < remaining))
      else $error("body byte index passed the end of the frame");

endmodule

FILE: rtl/mfd_queue.sv
// Two-entry result queue that lets requests flow while a result waits to be taken.
module mfd_queue import mfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       pop_ready,
   output logic       pop_valid,
   output result_type pop_data,
   output logic       has_room
);

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entry_ff[rd_ptr_ff];
   // Room counts the result arriving from the parser and the one leaving this cycle, so the
   // result of a request accepted now always finds a free entry when it reaches the queue.
   assign has_room  = (count_in != 2'd2);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !(push && !pop))
      else $error("result queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == 2'd0) || (count_ff == 2'd2)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("result queue pointers disagree with count");

endmodule

FILE: rtl/message_frame_decoder.sv
// Top level of the message frame decoder: register port, frame parser and result queue.
//
// The decoder takes one stream byte per request and accepts a request in every clock cycle in
// which req_if.ready is high; a byte's result, if it has one, passes through the parser's result
// register and then the result queue before it is offered on rsp_if.
// Results pass through a two-entry queue. req_if.ready drops in a cycle where the queue,
// counting the result on its way in and the one rsp_if takes in that cycle, would hold two
// results, so it follows rsp_if.ready within the cycle; with rsp_if.ready held high requests
// never stall. After a malformed frame is reported, bytes are still accepted but dropped until
// reset. Register writes on csr_if are always accepted and should be made only while the
// decoder is idle.
module message_frame_decoder import mfd_pkg::*; #(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
   input logic             clock,
   input logic             reset,
   mfd_byte_if.sink        req_if,
   mfd_result_if.source    rsp_if,
   mfd_csr_if.sink         csr_if
);

   cfg_type    cfg_ff, cfg_in;
   logic       req_fire;
   logic       core_valid;
   result_type core_result;
   result_type queue_data;
   logic       has_room;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            REG_VERSION_CODE: cfg_in.version_code = csr_if.data[7:0];
            REG_MAX_BODY:     cfg_in.max_body     = csr_if.data;
            REG_HELLO_CODE:   cfg_in.hello_code   = csr_if.data[7:0];
            REG_DATA_CODE:    cfg_in.data_code    = csr_if.data[7:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.version_code <= VERSION_CODE_RST;
         cfg_ff.max_body     <= MAX_BODY_RST;
         cfg_ff.hello_code   <= HELLO_CODE_RST;
         cfg_ff.data_code    <= DATA_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_if.ready = has_room;
   assign req_fire     = req_if.valid && has_room;

   mfd_core #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (req_fire),
      .in_byte    (req_if.data_byte),
      .cfg        (cfg_ff),
      .out_valid  (core_valid),
      .out_result (core_result)
   );

   mfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (core_valid),
      .push_data (core_result),
      .pop_ready (rsp_if.ready),
      .pop_valid (rsp_if.valid),
      .pop_data  (queue_data),
      .has_room  (has_room)
   );

   assign rsp_if.kind          = queue_data.kind;
   assign rsp_if.value_byte    = queue_data.value_byte;
   assign rsp_if.msg_type      = queue_data.msg_type;
   assign rsp_if.hop_count     = queue_data.hop_count;
   assign rsp_if.sequence_res  = queue_data.sequence_res;
   assign rsp_if.origin_length = queue_data.origin_length;
   assign rsp_if.frame_last    = queue_data.frame_last;

endmodule

FILE: tb/tb_message_frame_decoder.sv
// Self-checking testbench of the message frame decoder with a byte-level frame parser model.
`timescale 1ns / 1ps

module tb_message_frame_decoder;
   import mfd_pkg::*;

   localparam int LEN_BYTES     = LENGTH_WIDTH_DEF / 8;
   localparam int HOLD_CYCLES   = 60;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int GAP_PERCENT   = 15;

   typedef enum int {
      BAD_LONG,
      BAD_SHORT,
      BAD_VERSION,
      BAD_TYPE,
      BAD_ORIGIN
   } malform_type;

   logic clock = 1'b0;
   logic reset;

   mfd_byte_if   req_if ();
   mfd_result_if rsp_if ();
   mfd_csr_if    csr_if ();

   message_frame_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #4 clock = ~clock;

   // Bytes waiting to be offered, and results the parser model says must come back.
   logic [7:0] stream_bytes[$];
   result_type awaited_results[$];

   cfg_type cfg_now;

   // Parser model state.
   phase_type   parse_phase;
   logic [31:0] byte_count;
   logic [31:0] frame_len;
   logic [7:0]  held_type;
   logic [7:0]  held_hops;
   logic [7:0]  held_olen;
   logic [31:0] held_seq;
   bit          stream_dead;

   bit steady_flow;
   bit stall_go;
   int stall_left;
   int cycle_count  = 0;
   int bytes_taken  = 0;
   int results_seen = 0;
   int frames_queued;
   int mismatches   = 0;

   // Returns 1 when the byte produces a result, which is placed in r.
   function automatic bit decode_byte(input logic [7:0] b, output result_type r);
      logic [31:0] idx;
      logic [31:0] remaining;
      bit          emit_it;
      kind_type    out_kind;
      logic [7:0]  out_value;
      bit          out_last;
      emit_it   = 1'b0;
      out_kind  = KIND_MALFORMED;
      out_value = 8'h00;
      out_last  = 1'b1;
      r         = '0;
      if (stream_dead)
         return 1'b0;
      case (parse_phase)
         PH_LENGTH: begin
            if (byte_count == 0) begin
               frame_len = '0;
               held_type = '0;
               held_hops = '0;
               held_olen = '0;
               held_seq  = '0;
            end
            frame_len  = (frame_len << 8) | b;
            byte_count = byte_count + 1;
            if (byte_count == LEN_BYTES) begin
               byte_count = 0;
               if (frame_len > cfg_now.max_body || frame_len < HEADER_BYTES) begin
                  stream_dead = 1'b1;
                  emit_it     = 1'b1;
               end else begin
                  parse_phase = PH_HEADER;
               end
            end
         end
         PH_HEADER: begin
            idx        = byte_count;
            byte_count = byte_count + 1;
            case (idx)
               0: stream_dead = (b != cfg_now.version_code);
               1: begin
                  held_type   = b;
                  stream_dead = (b != cfg_now.hello_code && b != cfg_now.data_code);
               end
               2: held_hops = b;
               3: begin
                  held_olen   = b;
                  stream_dead = (HEADER_BYTES + b > frame_len);
               end
               default: held_seq = (held_seq << 8) | b;
            endcase
            if (stream_dead) begin
               emit_it = 1'b1;
            end else if (byte_count == HEADER_BYTES) begin
               byte_count = 0;
               if (frame_len == HEADER_BYTES) begin
                  parse_phase = PH_LENGTH;
                  emit_it     = 1'b1;
                  out_kind    = KIND_EMPTY;
               end else begin
                  parse_phase = PH_BODY;
               end
            end
         end
         default: begin
            remaining = frame_len - HEADER_BYTES;
            out_kind  = (byte_count < held_olen) ? KIND_ORIGIN : KIND_PAYLOAD;
            out_value = b;
            out_last  = (byte_count + 1 >= remaining);
            emit_it   = 1'b1;
            if (out_last) begin
               parse_phase = PH_LENGTH;
               byte_count  = 0;
            end else begin
               byte_count = byte_count + 1;
            end
         end
      endcase
      if (emit_it) begin
         r.kind          = out_kind;
         r.value_byte    = out_value;
         r.msg_type      = held_type;
         r.hop_count     = held_hops;
         r.sequence_res  = held_seq;
         r.origin_length = held_olen;
         r.frame_last    = out_last;
      end
      return emit_it;
   endfunction

   // Register shadow follows the write port.
   always @(posedge clock) begin
      if (reset) begin
         cfg_now <= '{version_code: VERSION_CODE_RST, max_body: MAX_BODY_RST,
                      hello_code: HELLO_CODE_RST, data_code: DATA_CODE_RST};
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            REG_VERSION_CODE: cfg_now.version_code <= csr_if.data[7:0];
            REG_MAX_BODY:     cfg_now.max_body     <= csr_if.data;
            REG_HELLO_CODE:   cfg_now.hello_code   <= csr_if.data[7:0];
            REG_DATA_CODE:    cfg_now.data_code    <= csr_if.data[7:0];
            default: ;
         endcase
      end
   end

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.data_byte <= 8'h00;
      end else if (!req_if.valid || req_if.ready) begin
         if (stream_bytes.size() != 0 &&
             (steady_flow || $urandom_range(99) >= GAP_PERCENT)) begin
            req_if.valid     <= 1'b1;
            req_if.data_byte <= stream_bytes.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Accepted requests run through the parser model.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         parse_phase = PH_LENGTH;
         byte_count  = '0;
         frame_len   = '0;
         held_type   = '0;
         held_hops   = '0;
         held_olen   = '0;
         held_seq    = '0;
         stream_dead = 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         bytes_taken++;
         if (decode_byte(req_if.data_byte, want))
            awaited_results.insert(awaited_results.size(), want);
      end
   end

   // Long receiver hold-off, counted here.
   always @(posedge clock) begin
      if (reset)
         stall_left <= 0;
      else if (stall_go)
         stall_left <= HOLD_CYCLES;
      else if (stall_left != 0)
         stall_left <= stall_left - 1;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= (stall_left == 0) && !stall_go &&
                         (steady_flow || $urandom_range(99) >= GAP_PERCENT);
   end

   // Result checker.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.kind          = kind_type'(rsp_if.kind);
         got.value_byte    = rsp_if.value_byte;
         got.msg_type      = rsp_if.msg_type;
         got.hop_count     = rsp_if.hop_count;
         got.sequence_res  = rsp_if.sequence_res;
         got.origin_length = rsp_if.origin_length;
         got.frame_last    = rsp_if.frame_last;
         results_seen++;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: kind %0d value %02h last %0d",
                        got.kind, got.value_byte, got.frame_last);
         end else begin
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.value_byte !== want.value_byte ||
                got.msg_type !== want.msg_type || got.hop_count !== want.hop_count ||
                got.sequence_res !== want.sequence_res ||
                got.origin_length !== want.origin_length ||
                got.frame_last !== want.frame_last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Mismatch at result %0d (kind value type hops seq olen last):",
                           results_seen);
                  $display("  expected %0d %02h %02h %02h %08h %02h %0d",
                           want.kind, want.value_byte, want.msg_type,
                           want.hop_count, want.sequence_res, want.origin_length,
                           want.frame_last);
                  $display("  actual   %0d %02h %02h %02h %08h %02h %0d",
                           got.kind, got.value_byte, got.msg_type, got.hop_count,
                           got.sequence_res, got.origin_length, got.frame_last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, awaited_results.size());
         $display("tb_message_frame_decoder NOT OK");
         $finish;
      end
   end

   task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   // The 8-bit registers get random upper bits, which the block must ignore.
   task automatic write_config(input logic [7:0] ver, input logic [31:0] max_len,
                               input logic [7:0] hello, input logic [7:0] data);
      write_reg(REG_VERSION_CODE, {24'($urandom), ver});
      write_reg(REG_MAX_BODY, max_len);
      write_reg(REG_HELLO_CODE, {24'($urandom), hello});
      write_reg(REG_DATA_CODE, {24'($urandom), data});
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (stream_bytes.size() != 0 || req_if.valid || awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic add_byte(input logic [7:0] b);
      stream_bytes.insert(stream_bytes.size(), b);
   endtask

   task automatic queue_frame(input logic [31:0] body_len, input logic [7:0] ver,
                              input logic [7:0] typ, input logic [7:0] hops,
                              input logic [7:0] olen, input logic [31:0] seq,
                              input int unsigned body_count);
      for (int i = LEN_BYTES - 1; i >= 0; i--)
         add_byte(body_len[8*i +: 8]);
      add_byte(ver);
      add_byte(typ);
      add_byte(hops);
      add_byte(olen);
      for (int i = 3; i >= 0; i--)
         add_byte(seq[8*i +: 8]);
      repeat (body_count) add_byte(8'($urandom));
      frames_queued++;
   endtask

   // Well-formed frame under the current settings; mostly short bodies, some long ones.
   task automatic queue_random_frame(inout int budget_left);
      logic [31:0] cap;
      logic [31:0] body_len;
      logic [7:0]  olen;
      logic [7:0]  olen_max;
      logic [7:0]  typ;
      int unsigned pick;
      int          room;
      cap  = (cfg_now.max_body > 400) ? 32'd400 : cfg_now.max_body;
      // The last frame of a budget is kept short so the byte count lands close to it.
      room = budget_left - LEN_BYTES;
      if (room < HEADER_BYTES)
         room = HEADER_BYTES;
      if (cap > 32'(room))
         cap = 32'(room);
      pick = $urandom_range(9);
      if (pick == 0)
         body_len = $urandom_range(cap, HEADER_BYTES);
      else if (pick == 1)
         body_len = cap;
      else if (pick == 2)
         body_len = HEADER_BYTES;
      else
         body_len = $urandom_range((cap > 40) ? 40 : cap, HEADER_BYTES);
      olen_max = (body_len - HEADER_BYTES > 255) ? 8'd255 : 8'(body_len - HEADER_BYTES);
      case ($urandom_range(3))
         0: olen = 8'd0;
         1: olen = olen_max;
         default: olen = 8'($urandom_range(olen_max, 0));
      endcase
      typ = $urandom_range(1) ? cfg_now.hello_code : cfg_now.data_code;
      queue_frame(body_len, cfg_now.version_code, typ, 8'($urandom), olen, $urandom,
                  body_len - HEADER_BYTES);
      budget_left -= LEN_BYTES + body_len;
   endtask

   task automatic run_frames(input int budget);
      while (budget > 0)
         queue_random_frame(budget);
   endtask

   initial begin
      malform_type mk;
      logic [31:0] bad_len;
      logic [7:0]  bad_type;
      reset            <= 1'b1;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= REG_VERSION_CODE;
      csr_if.data      <= '0;
      steady_flow   = 1'b0;
      stall_go      = 1'b0;
      frames_queued = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: an empty frame with extreme header fields, then a body of one origin byte.
      queue_frame(HEADER_BYTES, VERSION_CODE_RST, HELLO_CODE_RST, 8'hFF, 8'h00,
                  32'hFFFF_FFFF, 0);
      queue_frame(HEADER_BYTES + 1, VERSION_CODE_RST, DATA_CODE_RST, 8'h00, 8'h01,
                  32'h0000_0000, 1);
      wait_drained();

      // Reset settings, no idling; the receiver holds off while requests keep coming.
      steady_flow = 1'b1;
      stall_go    = 1'b1;
      run_frames(150);
      @(negedge clock);
      stall_go = 1'b0;
      wait_drained();
      steady_flow = 1'b0;

      // Smallest body limit: only empty frames pass.
      write_config(8'h00, HEADER_BYTES, 8'h00, 8'hFF);
      run_frames(60);
      wait_drained();

      write_config(8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'h00);
      run_frames(150);
      wait_drained();

      write_config(8'($urandom), $urandom_range(300, HEADER_BYTES), 8'($urandom),
                   8'($urandom));
      run_frames(150);
      wait_drained();

      write_config(VERSION_CODE_RST, 32'd1000, HELLO_CODE_RST, DATA_CODE_RST);
      run_frames(60);

      // One malformed frame closes the run; the frame after it must be dropped.
      mk = malform_type'($urandom_range(BAD_ORIGIN));
      case (mk)
         BAD_LONG:
            queue_frame(cfg_now.max_body + 1, cfg_now.version_code, cfg_now.hello_code,
                        8'($urandom), 8'h00, $urandom, 6);
         BAD_SHORT:
            queue_frame($urandom_range(HEADER_BYTES - 1), cfg_now.version_code,
                        cfg_now.hello_code, 8'($urandom), 8'h00, $urandom, 6);
         BAD_VERSION:
            queue_frame(20, cfg_now.version_code ^ 8'($urandom_range(255, 1)),
                        cfg_now.hello_code, 8'($urandom), 8'h00, $urandom, 12);
         BAD_TYPE: begin
            do bad_type = 8'($urandom);
            while (bad_type == cfg_now.hello_code || bad_type == cfg_now.data_code);
            queue_frame(20, cfg_now.version_code, bad_type, 8'($urandom), 8'h00,
                        $urandom, 12);
         end
         default: begin
            bad_len = HEADER_BYTES + $urandom_range(40);
            queue_frame(bad_len, cfg_now.version_code, cfg_now.data_code, 8'($urandom),
                        8'(bad_len - HEADER_BYTES + 1 + $urandom_range(50)), $urandom, 6);
         end
      endcase
      queue_frame(HEADER_BYTES + 4, cfg_now.version_code, cfg_now.hello_code, 8'h01,
                  8'h02, $urandom, 4);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d frames as %0d stream bytes under five register settings; %0d results.",
               frames_queued, bytes_taken, results_seen);
      $display("The last good frame was followed by a %s error and the bytes after it were dropped.",
               mk.name());
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("tb_message_frame_decoder OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches,
                  awaited_results.size());
         $display("tb_message_frame_decoder NOT OK");
      end
      $finish;
   end

endmodule
